FILE: hw/rtl/gmdfs_pkg.sv
// Shared types, codes and defaults for the grid maze depth-first search block.
package gmdfs_pkg;

   localparam int GRID_ROWS_DEFAULT = 6;
   localparam int GRID_COLS_DEFAULT = 6;

   localparam int COORD_W = 3;
   localparam int KIND_W  = 2;
   localparam int EV_W    = 2;
   localparam int DIR_W   = 2;

   // request kinds (req_tuser)
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // cell kinds
   localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GOAL  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_START = 2'd3;

   // result event kinds (rsp_tuser)
   localparam logic [EV_W-1:0] EV_ENTER   = 2'd0;
   localparam logic [EV_W-1:0] EV_GOAL    = 2'd1;
   localparam logic [EV_W-1:0] EV_EXHAUST = 2'd2;

   // neighbor order: right, down, left, up
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

   typedef struct packed {
      logic [DIR_W-1:0]   dir;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } stk_entry_type;

   typedef struct packed {
      logic            load_wr;    // write loaded cell, clear its visited mark
      logic            start;      // take start coordinate, clear stack, read its kind
      logic            kind_rd;    // take neighbor as candidate, read its kind
      logic            stack_rd;   // read stack top
      logic            stack_step; // advance top direction or pop it
      logic            push;       // mark candidate visited and push it
      logic            emit;       // load result register
      logic [EV_W-1:0] emit_kind;
      logic            goal_done;  // clear stack after goal
   } cmd_type;

   typedef struct packed {
      logic req_in_bounds;
      logic depth_zero;
      logic cand_goal;
      logic cand_enterable;
      logic nbr_in_bounds;
      logic rsp_free;
   } status_type;

endpackage

FILE: hw/rtl/grid_maze_depth_first_search_top.sv
// Grid maze depth-first search: top level with sequencer and datapath.
//
// Input channel (req_*): req_tuser 0 loads one cell (kind in req_tdata), 1
// starts a search at the given coordinate. A load gives no result; loads
// can stream one per cycle while no search runs. A load outside the grid
// is dropped. Loading a cell clears its visited mark.
// Result channel (rsp_*): one item per entered open cell, then a final item
// with rsp_tlast set: goal reached, or exhausted with zero position.
// Flow: a search holds req_tready low until its final item is in the
// result register. Each neighbor try reads the stack top, then updates it
// while reading the neighbor's kind, then evaluates the neighbor; a try
// off the grid skips the evaluation. Each cell on the stack gets 4 tries
// before it is popped. For a start inside the grid, its kind is read on
// acceptance and evaluated before the first result is loaded.
// Stalls: one result register; the walk waits to emit while it holds an
// untaken item. Reset clears the visited marks, the stack depth and the
// handshake state; cell kinds are undefined until loaded.
module grid_maze_depth_first_search_top #(
   parameter int GRID_ROWS = gmdfs_pkg::GRID_ROWS_DEFAULT,
   parameter int GRID_COLS = gmdfs_pkg::GRID_COLS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // cell_x[2:0], cell_y[5:3], cell_code[7:6]
   input  logic       req_tuser,  // req_type
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // pos_x[2:0], pos_y[5:3], zero[7:6]
   output logic [1:0] rsp_tuser,  // event_kind
   output logic       rsp_tlast   // last
);

   gmdfs_pkg::cmd_type    cmd;
   gmdfs_pkg::status_type sts;
   logic [gmdfs_pkg::COORD_W-1:0] rsp_x, rsp_y;

   gmdfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   gmdfs_dp #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_x     (req_tdata[2:0]),
      .req_y     (req_tdata[5:3]),
      .req_code  (req_tdata[7:6]),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_kind  (rsp_tuser),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_y, rsp_x};

   // final items are exactly the goal and exhausted ones
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != gmdfs_pkg::EV_ENTER)))
      else $error("tlast does not match event kind");

   a_exh_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == gmdfs_pkg::EV_EXHAUST)) |-> (rsp_tdata == 8'd0))
      else $error("exhausted item carries a position");

   // a search blocks the input channel at least for the next cycle
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == gmdfs_pkg::REQ_SEARCH)) |=> !req_tready)
      else $error("item accepted while a search runs");

endmodule

FILE: hw/rtl/gmdfs_ctrl.sv
// Search sequencer: steps the walk and issues datapath commands.
module gmdfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_kind,
   input  gmdfs_pkg::status_type sts,
   output gmdfs_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_VEVAL = 3'd1;
   localparam logic [2:0] S_POP   = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_EXH   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.emit_kind = gmdfs_pkg::EV_ENTER;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == gmdfs_pkg::REQ_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = sts.req_in_bounds ? S_VEVAL : S_POP;
               end
            end
         end
         S_VEVAL: begin
            if (sts.cand_goal) begin
               if (sts.rsp_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = gmdfs_pkg::EV_GOAL;
                  cmd.goal_done = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (sts.cand_enterable) begin
               if (sts.rsp_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = gmdfs_pkg::EV_ENTER;
                  cmd.push      = 1'b1;
                  state_in      = S_POP;
               end
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (sts.depth_zero) begin
               state_in = S_EXH;
            end else begin
               cmd.stack_rd = 1'b1;
               state_in     = S_STEP;
            end
         end
         S_STEP: begin
            cmd.stack_step = 1'b1;
            cmd.kind_rd    = 1'b1;
            state_in       = sts.nbr_in_bounds ? S_VEVAL : S_POP;
         end
         S_EXH: begin
            if (sts.rsp_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = gmdfs_pkg::EV_EXHAUST;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/gmdfs_dp.sv
// Datapath: cell kind memory, visited marks, walk stack and result register.
module gmdfs_dp #(
   parameter int GRID_ROWS = gmdfs_pkg::GRID_ROWS_DEFAULT,
   parameter int GRID_COLS = gmdfs_pkg::GRID_COLS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [gmdfs_pkg::COORD_W-1:0]        req_x,
   input  logic [gmdfs_pkg::COORD_W-1:0]        req_y,
   input  logic [gmdfs_pkg::KIND_W-1:0]         req_code,
   input  gmdfs_pkg::cmd_type                   cmd,
   output gmdfs_pkg::status_type                sts,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [gmdfs_pkg::EV_W-1:0]           rsp_kind,
   output logic [gmdfs_pkg::COORD_W-1:0]        rsp_x,
   output logic [gmdfs_pkg::COORD_W-1:0]        rsp_y,
   output logic                                 rsp_last
);

   localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
   localparam int CW         = gmdfs_pkg::COORD_W;

   function automatic logic [IDX_W-1:0] cell_idx(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] y);
      return IDX_W'(int'(y) * GRID_COLS + int'(x));
   endfunction

   logic [gmdfs_pkg::KIND_W-1:0] kind_mem [CELL_COUNT];
   gmdfs_pkg::stk_entry_type     stack_mem [CELL_COUNT];

   logic [gmdfs_pkg::KIND_W-1:0] kind_rd_ff;
   gmdfs_pkg::stk_entry_type     stk_rd_ff;
   logic [CELL_COUNT-1:0]        visited_ff;
   logic [DEPTH_W-1:0]           depth_ff;
   logic [CW-1:0]                cand_x_ff, cand_y_ff;
   logic [IDX_W-1:0]             cand_idx_ff;

   logic                         rsp_valid_ff;
   logic [gmdfs_pkg::EV_W-1:0]   rsp_kind_ff;
   logic [CW-1:0]                rsp_x_ff, rsp_y_ff;
   logic                         rsp_last_ff;

   logic [IDX_W-1:0]             req_idx, nbr_idx, kind_rd_idx;
   logic [DEPTH_W-1:0]           depth_m1;
   logic [CW:0]                  nx_w, ny_w;
   logic [CW-1:0]                nbr_x, nbr_y;
   logic                         nbr_ok, stk_last_dir;
   gmdfs_pkg::stk_entry_type     stk_next, push_entry;

   assign req_idx  = cell_idx(req_x, req_y);
   assign depth_m1 = depth_ff - DEPTH_W'(1);

   // neighbor of the stack top in its current direction, with bounds check
   always_comb begin
      nx_w   = {1'b0, stk_rd_ff.x};
      ny_w   = {1'b0, stk_rd_ff.y};
      nbr_ok = 1'b0;
      case (stk_rd_ff.dir)
         gmdfs_pkg::DIR_RIGHT: begin
            nx_w   = {1'b0, stk_rd_ff.x} + (CW+1)'(1);
            nbr_ok = nx_w < (CW+1)'(GRID_COLS);
         end
         gmdfs_pkg::DIR_DOWN: begin
            ny_w   = {1'b0, stk_rd_ff.y} + (CW+1)'(1);
            nbr_ok = ny_w < (CW+1)'(GRID_ROWS);
         end
         gmdfs_pkg::DIR_LEFT: begin
            nx_w   = {1'b0, stk_rd_ff.x} - (CW+1)'(1);
            nbr_ok = stk_rd_ff.x != '0;
         end
         default: begin
            ny_w   = {1'b0, stk_rd_ff.y} - (CW+1)'(1);
            nbr_ok = stk_rd_ff.y != '0;
         end
      endcase
   end

   assign nbr_x        = nx_w[CW-1:0];
   assign nbr_y        = ny_w[CW-1:0];
   assign nbr_idx      = cell_idx(nbr_x, nbr_y);
   assign kind_rd_idx  = cmd.start ? req_idx : nbr_idx;
   assign stk_last_dir = (stk_rd_ff.dir == gmdfs_pkg::DIR_UP);

   always_comb begin
      stk_next     = stk_rd_ff;
      stk_next.dir = stk_rd_ff.dir + gmdfs_pkg::DIR_W'(1);
      push_entry.x   = cand_x_ff;
      push_entry.y   = cand_y_ff;
      push_entry.dir = gmdfs_pkg::DIR_RIGHT;
   end

   assign sts.req_in_bounds  = ({1'b0, req_x} < (CW+1)'(GRID_COLS))
                            && ({1'b0, req_y} < (CW+1)'(GRID_ROWS));
   assign sts.depth_zero     = (depth_ff == '0);
   assign sts.cand_goal      = (kind_rd_ff == gmdfs_pkg::KIND_GOAL);
   assign sts.cand_enterable = (kind_rd_ff == gmdfs_pkg::KIND_OPEN)
                            && !visited_ff[cand_idx_ff];
   assign sts.nbr_in_bounds  = nbr_ok;
   assign sts.rsp_free       = !rsp_valid_ff || rsp_ready;

   // cell kind memory
   always_ff @(posedge clock) begin
      if (cmd.load_wr && sts.req_in_bounds) begin
         kind_mem[req_idx] <= req_code;
      end
      if (cmd.start || cmd.kind_rd) begin
         kind_rd_ff <= kind_mem[kind_rd_idx];
      end
   end

   // walk stack memory; push and top update never share a cycle
   always_ff @(posedge clock) begin
      if (cmd.push && (depth_ff < DEPTH_W'(CELL_COUNT))) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= push_entry;
      end else if (cmd.stack_step && !stk_last_dir) begin
         stack_mem[depth_m1[IDX_W-1:0]] <= stk_next;
      end
      if (cmd.stack_rd) begin
         stk_rd_ff <= stack_mem[depth_m1[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cand_x_ff   <= req_x;
         cand_y_ff   <= req_y;
         cand_idx_ff <= req_idx;
      end else if (cmd.kind_rd) begin
         cand_x_ff   <= nbr_x;
         cand_y_ff   <= nbr_y;
         cand_idx_ff <= nbr_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         depth_ff   <= '0;
      end else begin
         if (cmd.load_wr && sts.req_in_bounds) begin
            visited_ff[req_idx] <= 1'b0;
         end else if (cmd.push) begin
            visited_ff[cand_idx_ff] <= 1'b1;
         end
         if (cmd.start || cmd.goal_done) begin
            depth_ff <= '0;
         end else if (cmd.push) begin
            if (depth_ff < DEPTH_W'(CELL_COUNT)) begin
               depth_ff <= depth_ff + DEPTH_W'(1);
            end
         end else if (cmd.stack_step && stk_last_dir) begin
            depth_ff <= depth_m1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.emit_kind;
         rsp_last_ff <= (cmd.emit_kind != gmdfs_pkg::EV_ENTER);
         if (cmd.emit_kind == gmdfs_pkg::EV_EXHAUST) begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
         end else begin
            rsp_x_ff <= cand_x_ff;
            rsp_y_ff <= cand_y_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_x     = rsp_x_ff;
   assign rsp_y     = rsp_y_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

FILE: bench/grid_maze_depth_first_search_top_test.sv
// Self-checking bench for the grid maze depth-first search block.
module grid_maze_depth_first_search_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS  = gmdfs_pkg::GRID_ROWS_DEFAULT;
   localparam int COLS  = gmdfs_pkg::GRID_COLS_DEFAULT;
   localparam int CELLS = ROWS * COLS;

   typedef struct {
      logic       kind;   // REQ_LOAD or REQ_SEARCH
      logic [2:0] x;
      logic [2:0] y;
      logic [1:0] code;
      bit         drain;  // hold until every pending result has come back
      bit         calm;   // no idling on either side
   } request_type;

   typedef struct {
      logic [1:0] ev;
      logic [2:0] x;
      logic [2:0] y;
      logic       last;
   } maze_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;  // cell_x[2:0], cell_y[5:3], cell_code[7:6]
   logic       req_tuser = 1'b0;  // req_type
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // pos_x[2:0], pos_y[5:3], zero[7:6]
   logic [1:0] rsp_tuser;         // event_kind
   logic       rsp_tlast;

   request_type    request_q[$];
   maze_event_type expected_events_q[$];
   int             sent_count;
   int             total_items;
   int             error_count;
   int             send_gap;
   int             stall_left;
   bit             calm_phase;

   // predictor state
   logic [1:0] kind_map [CELLS];
   bit         visited [CELLS];
   logic [7:0] walk_mem [CELLS];  // direction in [7:6], cell index in [5:0]
   int         walk_depth;

   grid_maze_depth_first_search_top #(
      .GRID_ROWS(ROWS),
      .GRID_COLS(COLS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Tries one cell of the walk; returns 1 when the goal ends the search.
   function automatic bit probe_cell(int x, int y);
      int idx;
      if (x < 0 || x >= COLS || y < 0 || y >= ROWS) return 1'b0;
      idx = y * COLS + x;
      if (kind_map[idx] == gmdfs_pkg::KIND_GOAL) begin
         expected_events_q.push_back('{gmdfs_pkg::EV_GOAL, 3'(x), 3'(y), 1'b1});
         walk_depth = 0;
         return 1'b1;
      end
      if (kind_map[idx] == gmdfs_pkg::KIND_OPEN && !visited[idx]) begin
         visited[idx] = 1'b1;
         expected_events_q.push_back('{gmdfs_pkg::EV_ENTER, 3'(x), 3'(y), 1'b0});
         if (walk_depth < CELLS) begin
            walk_mem[walk_depth] = {gmdfs_pkg::DIR_RIGHT, 6'(idx)};
            walk_depth++;
         end
      end
      return 1'b0;
   endfunction

   function automatic void walk_maze(int sx, int sy);
      int         top;
      int         idx;
      int         nx;
      int         ny;
      logic [1:0] dir;
      walk_depth = 0;
      if (probe_cell(sx, sy)) return;
      while (walk_depth > 0) begin
         top = walk_depth - 1;
         idx = int'(walk_mem[top][5:0]);
         dir = walk_mem[top][7:6];
         nx  = idx % COLS;
         ny  = idx / COLS;
         if (dir == gmdfs_pkg::DIR_UP) walk_depth = top;
         else walk_mem[top] = {2'(dir + 2'd1), 6'(idx)};
         case (dir)
            gmdfs_pkg::DIR_RIGHT: nx++;
            gmdfs_pkg::DIR_DOWN:  ny++;
            gmdfs_pkg::DIR_LEFT:  nx--;
            default:              ny--;
         endcase
         if (probe_cell(nx, ny)) return;
      end
      expected_events_q.push_back('{gmdfs_pkg::EV_EXHAUST, 3'd0, 3'd0, 1'b1});
   endfunction

   function automatic void predict_request(logic kind, logic [7:0] data);
      int x;
      int y;
      x = int'(data[2:0]);
      y = int'(data[5:3]);
      if (kind == gmdfs_pkg::REQ_LOAD) begin
         if (x < COLS && y < ROWS) begin
            kind_map[y * COLS + x] = data[7:6];
            visited[y * COLS + x]  = 1'b0;
         end
      end else begin
         walk_maze(x, y);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata);
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_q.size() > 0 && !request_q[0].calm && send_gap == 0 &&
                $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 4);
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (request_q.size() > 0 &&
                         !(request_q[0].drain && expected_events_q.size() > 0)) begin
               calm_phase = request_q[0].calm;
               req_tvalid <= 1'b1;
               req_tuser  <= request_q[0].kind;
               req_tdata  <= {request_q[0].code, request_q[0].y, request_q[0].x};
               void'(request_q.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      maze_event_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected result kind %0d at (%0d,%0d)",
                                       rsp_tuser, rsp_tdata[2:0], rsp_tdata[5:3]));
            end else begin
               want = expected_events_q.pop_front();
               if (rsp_tuser !== want.ev)
                  flag_mismatch($sformatf("event kind %0d, want %0d", rsp_tuser, want.ev));
               if (rsp_tdata[2:0] !== want.x)
                  flag_mismatch($sformatf("pos_x %0d, want %0d", rsp_tdata[2:0], want.x));
               if (rsp_tdata[5:3] !== want.y)
                  flag_mismatch($sformatf("pos_y %0d, want %0d", rsp_tdata[5:3], want.y));
               if (rsp_tdata[7:6] !== 2'b00)
                  flag_mismatch($sformatf("pad bits %b, want 00", rsp_tdata[7:6]));
               if (rsp_tlast !== want.last)
                  flag_mismatch($sformatf("last %b, want %b", rsp_tlast, want.last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_item(logic kind, int x, int y, logic [1:0] code, bit drain = 1'b0);
      request_q.push_back('{kind, 3'(x), 3'(y), code, drain, 1'b0});
   endtask

   function automatic logic [1:0] pick_code(int wall_pct, int goal_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < wall_pct) return gmdfs_pkg::KIND_WALL;
      if (r < wall_pct + goal_pct) return gmdfs_pkg::KIND_GOAL;
      if (r < wall_pct + goal_pct + 4) return gmdfs_pkg::KIND_START;
      return gmdfs_pkg::KIND_OPEN;
   endfunction

   task automatic fill_maze(int wall_pct, int goal_pct);
      for (int y = 0; y < ROWS; y++)
         for (int x = 0; x < COLS; x++)
            queue_item(gmdfs_pkg::REQ_LOAD, x, y, pick_code(wall_pct, goal_pct));
   endtask

   initial begin
      timeout_guard();
   end

   task automatic timeout_guard();
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   endtask

   initial begin
      int         reloads;
      int         sx;
      int         sy;
      int         cx;
      int         cy;
      logic [1:0] code;

      // Every cell gets a kind before any search can read it.
      for (int y = 0; y < ROWS; y++)
         for (int x = 0; x < COLS; x++)
            queue_item(gmdfs_pkg::REQ_LOAD, x, y, gmdfs_pkg::KIND_OPEN);

      // directed: corridors, a goal in the far corner, a start marker
      queue_item(gmdfs_pkg::REQ_LOAD, 1, 0, gmdfs_pkg::KIND_WALL);
      queue_item(gmdfs_pkg::REQ_LOAD, 1, 1, gmdfs_pkg::KIND_WALL);
      queue_item(gmdfs_pkg::REQ_LOAD, 3, 4, gmdfs_pkg::KIND_WALL);
      queue_item(gmdfs_pkg::REQ_LOAD, COLS - 1, ROWS - 1, gmdfs_pkg::KIND_GOAL);
      queue_item(gmdfs_pkg::REQ_LOAD, 0, ROWS - 1, gmdfs_pkg::KIND_START);
      // loads off the grid are dropped
      queue_item(gmdfs_pkg::REQ_LOAD, 7, 7, gmdfs_pkg::KIND_START);
      queue_item(gmdfs_pkg::REQ_LOAD, COLS, 0, gmdfs_pkg::KIND_WALL);
      queue_item(gmdfs_pkg::REQ_LOAD, 0, ROWS, gmdfs_pkg::KIND_GOAL);
      // blocked starts: off grid, wall, start marker
      queue_item(gmdfs_pkg::REQ_SEARCH, 7, 7, 2'd3);
      queue_item(gmdfs_pkg::REQ_SEARCH, COLS, 2, 2'd0);
      queue_item(gmdfs_pkg::REQ_SEARCH, 1, 1, 2'd0);
      queue_item(gmdfs_pkg::REQ_SEARCH, 0, ROWS - 1, 2'd0);
      // start on the goal itself
      queue_item(gmdfs_pkg::REQ_SEARCH, COLS - 1, ROWS - 1, 2'd1);
      // full walk ending at the goal, then the same start is already visited
      queue_item(gmdfs_pkg::REQ_SEARCH, 0, 0, 2'd2);
      queue_item(gmdfs_pkg::REQ_SEARCH, 0, 0, 2'd0);
      // reopen a few cells, remove the goal: short walk that runs dry
      queue_item(gmdfs_pkg::REQ_LOAD, COLS - 1, ROWS - 1, gmdfs_pkg::KIND_WALL);
      queue_item(gmdfs_pkg::REQ_LOAD, 0, 0, gmdfs_pkg::KIND_OPEN);
      queue_item(gmdfs_pkg::REQ_LOAD, 0, 1, gmdfs_pkg::KIND_OPEN);
      queue_item(gmdfs_pkg::REQ_LOAD, 0, 2, gmdfs_pkg::KIND_OPEN);
      queue_item(gmdfs_pkg::REQ_SEARCH, 0, 1, 2'd0, 1'b1);

      // open but for the odd start marker, no goal: a long run of results
      fill_maze(0, 0);
      queue_item(gmdfs_pkg::REQ_SEARCH, COLS - 1, ROWS - 1, 2'd3, 1'b1);

      // random reloads and searches up to about a hundred items in all
      while (request_q.size() < 105) begin
         sx = $urandom_range(0, 7);
         sy = $urandom_range(0, 7);
         reloads = $urandom_range(1, 6);
         for (int i = 0; i < reloads; i++) begin
            cx = $urandom_range(0, COLS - 1);
            cy = $urandom_range(0, ROWS - 1);
            code = pick_code(20, 8);
            queue_item(gmdfs_pkg::REQ_LOAD, cx, cy, code);
            if (code == gmdfs_pkg::KIND_OPEN) begin
               sx = cx;
               sy = cy;
            end
         end
         // occasional noise: a load that falls off the grid
         if ($urandom_range(0, 7) == 0)
            queue_item(gmdfs_pkg::REQ_LOAD, $urandom_range(COLS, 7), $urandom_range(0, 7),
                       2'($urandom_range(0, 3)));
         if ($urandom_range(0, 4) == 0) begin
            sx = $urandom_range(0, 7);
            sy = $urandom_range(0, 7);
         end
         queue_item(gmdfs_pkg::REQ_SEARCH, sx, sy, 2'($urandom_range(0, 3)),
                    $urandom_range(0, 9) == 0);
      end

      // last stretch runs without idling
      for (int i = (request_q.size() > 30 ? request_q.size() - 30 : 0);
           i < request_q.size(); i++)
         request_q[i].calm = 1'b1;

      total_items = request_q.size();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total_items) @(posedge clock);
      while (expected_events_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
